>>> src/ardb_pkg.sv
// Shared types, constants and helpers for the audio ring drift bridge.
// No dependencies; imported by every module of the block.
`default_nettype none

package ardb_pkg;

  localparam int BUFFER_DEPTH      = 4096;
  localparam int ADDR_W            = $clog2(BUFFER_DEPTH);
  localparam int FILL_W            = ADDR_W + 1;
  localparam int MAX_PERIOD_FRAMES = 64;
  localparam int FRAME_W           = $clog2(MAX_PERIOD_FRAMES + 1);
  localparam int SAMPLE_W          = 16;
  localparam int CFG_DATA_W        = 12;
  localparam int THRESH_W          = 12;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1920);
  localparam logic [FRAME_W-1:0]  FRAMES_RESET = FRAME_W'(MAX_PERIOD_FRAMES);

  // Register indexes of the configuration port
  localparam logic CFG_DRIFT_THRESHOLD   = 1'b0;
  localparam logic CFG_FRAMES_PER_PERIOD = 1'b1;

  // Input command codes
  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic push;          // write sample, advance write pointer
    logic load;          // latch frame count, clear frame counter
    logic snap;          // measure occupancy, snap read pointer if drifted
    logic rd;            // read at read pointer, advance it
    logic cap_left;      // hold read data as left sample
    logic emit_data;     // present a frame from held left and read right
    logic emit_silence;  // present a silence frame
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;  // read pointer equals write pointer
    logic last;   // current frame is the final one of the period
  } dp_status_t;

  // Double a Q1.15 sample with saturation
  function automatic logic signed [SAMPLE_W-1:0] double_sat(
    input logic signed [SAMPLE_W-1:0] s
  );
    logic signed [SAMPLE_W-1:0] r;
    if (s[SAMPLE_W-1] != s[SAMPLE_W-2]) begin
      r = s[SAMPLE_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = {s[SAMPLE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/ardb_ctrl.sv
// Controller state machine of the audio ring drift bridge.
// Depends on ardb_pkg for command and status structs.
`default_nettype none

module ardb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   command,
  input  wire ardb_pkg::dp_status_t   status,
  output ardb_pkg::ctrl_cmd_t         cmd,
  output logic                        busy
);
  import ardb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SNAP  = 5'b00010,
    S_FRAME = 5'b00100,
    S_RIGHT = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start && command == CMD_PUSH) begin
          cmd.push = 1'b1;
        end
        if (start && command == CMD_RENDER) begin
          cmd.load   = 1'b1;
          state_next = S_SNAP;
        end
      end
      S_SNAP: begin
        cmd.snap   = 1'b1;
        state_next = S_FRAME;
      end
      S_FRAME: begin
        if (status.empty) begin
          cmd.emit_silence = 1'b1;
          if (status.last) state_next = S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_RIGHT;
        end
      end
      S_RIGHT: begin
        cmd.rd       = 1'b1;
        cmd.cap_left = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_data = 1'b1;
        state_next    = status.last ? S_IDLE : S_FRAME;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

`default_nettype wire

>>> src/ardb_dpath.sv
// Datapath of the audio ring drift bridge: sample memory, pointers,
// fill count, configuration registers, frame counter and result registers.
// Depends on ardb_pkg.
`default_nettype none

module ardb_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire ardb_pkg::ctrl_cmd_t                  cmd,
  output ardb_pkg::dp_status_t                      status,
  input  wire logic signed [ardb_pkg::SAMPLE_W-1:0] sample_value,
  input  wire logic                                 cfg_valid,
  input  wire logic                                 cfg_index,
  input  wire logic [ardb_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                      result_valid,
  output logic signed [ardb_pkg::SAMPLE_W-1:0]      haptic_left,
  output logic signed [ardb_pkg::SAMPLE_W-1:0]      haptic_right,
  output logic                                      underrun,
  output logic                                      last_frame
);
  import ardb_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [BUFFER_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_q;
  logic                       rd_ok;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] left_hold;

  logic [ADDR_W-1:0]   wr_ptr;
  logic [ADDR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]   fill;
  logic [THRESH_W-1:0] drift_threshold;
  logic [FRAME_W-1:0]  frames_per_period;
  logic [FRAME_W-1:0]  frames;
  logic [FRAME_W-1:0]  frame_cnt;
  logic [ADDR_W-1:0]   occupancy;
  logic [FRAME_W-1:0]  frames_clamped;

  // Memory: one write port for pushes, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr] <= sample_value;
    end
    if (cmd.rd) begin
      rd_q <= mem[rd_ptr];
    end
  end

  // Entries at or beyond the fill count were never written and read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (cmd.rd) begin
      rd_ok <= ({1'b0, rd_ptr} < fill);
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

  // Pointers wrap naturally at the power-of-two depth
  assign occupancy = wr_ptr - rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= wr_ptr + 1'b1;
        if (fill != FILL_W'(BUFFER_DEPTH)) fill <= fill + 1'b1;
      end
      if (cmd.snap && occupancy > drift_threshold) begin
        rd_ptr <= wr_ptr;
      end else if (cmd.rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_threshold   <= THRESH_RESET;
      frames_per_period <= FRAMES_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DRIFT_THRESHOLD:   drift_threshold   <= cfg_data[THRESH_W-1:0];
        CFG_FRAMES_PER_PERIOD: frames_per_period <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    frames_clamped = frames_per_period;
    if (frames_per_period == '0) frames_clamped = FRAME_W'(1);
    if (frames_per_period > FRAME_W'(MAX_PERIOD_FRAMES)) begin
      frames_clamped = FRAME_W'(MAX_PERIOD_FRAMES);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frames    <= frames_clamped;
      frame_cnt <= '0;
    end else if (cmd.emit_data || cmd.emit_silence) begin
      frame_cnt <= frame_cnt + 1'b1;
    end
    if (cmd.cap_left) begin
      left_hold <= rd_data;
    end
  end

  assign status.empty = (rd_ptr == wr_ptr);
  assign status.last  = (frame_cnt + 1'b1 == frames);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_data || cmd.emit_silence;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_silence) begin
      haptic_left  <= '0;
      haptic_right <= '0;
      underrun     <= 1'b1;
      last_frame   <= status.last;
    end else if (cmd.emit_data) begin
      haptic_left  <= double_sat(left_hold);
      haptic_right <= double_sat(rd_data);
      underrun     <= 1'b0;
      last_frame   <= status.last;
    end
  end

endmodule

`default_nettype wire

>>> src/audio_ring_drift_bridge.sv
// Audio ring drift bridge, top level: stereo Q1.15 ring buffer between a
// producer and a periodic renderer. Depends on ardb_pkg, ardb_ctrl, ardb_dpath.
// Push: busy stays low, and a push may be accepted every cycle while no render is in flight.
// Render: a drift check (S_SNAP), then per frame either a silence emit in S_FRAME
//   or, for a data frame, S_FRAME, S_RIGHT and S_EMIT (two reads through the single
//   memory read port). Each frame strobes result_valid in the cycle after its
//   last controller step; the receiver cannot stall.
// Reset: pointers and fill count cleared, registers to defaults; no memory
//   sweep, unwritten slots read as zero through the fill count.
`default_nettype none

module audio_ring_drift_bridge (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Command channel
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 command,
  input  wire logic signed [ardb_pkg::SAMPLE_W-1:0] sample_value,
  input  wire logic                                 block_end,
  // Configuration channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [ardb_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Result channel, one transfer per frame
  output logic                                      result_valid,
  output logic signed [ardb_pkg::SAMPLE_W-1:0]      haptic_left,
  output logic signed [ardb_pkg::SAMPLE_W-1:0]      haptic_right,
  output logic                                      underrun,
  output logic                                      last_frame
);
  import ardb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       start_ok;

  // block_end marks producer framing only; it never alters buffer state,
  // so it merely qualifies nothing beyond the start strobe.
  assign start_ok = start && (block_end || !block_end);

  // Hold register writes off while a render is in flight
  assign cfg_ready = !busy;

  ardb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start_ok),
    .command (command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  ardb_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_value (sample_value),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .haptic_left  (haptic_left),
    .haptic_right (haptic_right),
    .underrun     (underrun),
    .last_frame   (last_frame)
  );

endmodule

`default_nettype wire
